// ===== design/srl_pkg.sv =====
// ----------------------------------------------------------------------------
// srl_pkg: shared types and constants of the sorted ready list
// Node pool size, key width, operation and status codes, front/back command.
// ----------------------------------------------------------------------------
package srl_pkg;

	localparam int NODES     = 16;
	localparam int KEY_WIDTH = 32;
	localparam int ID_W      = $clog2(NODES);
	localparam int CNT_W     = $clog2(NODES + 1);

	typedef logic [ID_W-1:0]      id_t;
	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic op;
		id_t  id;
		key_t key;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		id_t        head_id;
		logic       head_valid;
		id_t        cursor_id;
		logic       cursor_valid;
		cnt_t       entries;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_HEAD,
		S_RD_TAIL,
		S_CLASSIFY,
		S_WALK_RD,
		S_WALK_CMP,
		S_LINK_RD,
		S_LINK_WR,
		S_RM_RD,
		S_RM_WR,
		S_DONE
	} state_t;

endpackage

// ===== design/srl_front.sv =====
// ----------------------------------------------------------------------------
// srl_front: input queue
// Two-entry queue that takes input transfers and hands commands to the back end.
// ----------------------------------------------------------------------------
module srl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  srl_pkg::cmd_t     in_cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output srl_pkg::cmd_t     cmd
);

	srl_pkg::cmd_t buf_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) buf_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (cmd_valid && cmd_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end

endmodule

// ===== design/srl_back.sv =====
// ----------------------------------------------------------------------------
// srl_back: list engine
// Sequencer over the key and link memories; one operation at a time.
// ----------------------------------------------------------------------------
module srl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  srl_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output srl_pkg::rsp_t rsp
);

	// memories: registered read data; one read port each, next_mem a second for the cursor
	srl_pkg::key_t key_mem  [srl_pkg::NODES];
	srl_pkg::id_t  next_mem [srl_pkg::NODES];
	srl_pkg::id_t  prev_mem [srl_pkg::NODES];

	logic [srl_pkg::NODES-1:0] listed_q;
	srl_pkg::id_t  head_q, tail_q, cur_q;
	logic          cur_ok_q;
	srl_pkg::cnt_t count_q;

	srl_pkg::state_t state_q, state_d;
	srl_pkg::cmd_t   op_q;
	srl_pkg::id_t    walk_q, at_q, after_q;
	srl_pkg::key_t   hkey_q;
	logic [srl_pkg::ID_W:0] steps_q;
	logic [1:0]      status_q;

	// read address/data
	srl_pkg::id_t  key_ra, link_ra;
	srl_pkg::key_t key_rd;
	srl_pkg::id_t  next_rd, prev_rd;
	// write controls
	logic          key_we, nx_we0, nx_we1, pv_we0, pv_we1;
	srl_pkg::id_t  nx_a0, nx_d0, nx_a1, nx_d1, pv_a0, pv_d0, pv_a1, pv_d1;
	srl_pkg::rsp_t rsp_q;
	logic          rsp_v_q;

	always_ff @(posedge clk) begin
		key_rd  <= key_mem[key_ra];
		next_rd <= next_mem[link_ra];
		prev_rd <= prev_mem[link_ra];
		if (key_we) key_mem[op_q.id] <= op_q.key;
		if (nx_we0) next_mem[nx_a0] <= nx_d0;
		if (nx_we1) next_mem[nx_a1] <= nx_d1;
		if (pv_we0) prev_mem[pv_a0] <= pv_d0;
		if (pv_we1) prev_mem[pv_a1] <= pv_d1;
	end

	assign cmd_ready = (state_q == srl_pkg::S_IDLE);
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		key_ra  = head_q;
		link_ra = walk_q;
		key_we  = 1'b0;
		nx_we0 = 1'b0; nx_we1 = 1'b0; pv_we0 = 1'b0; pv_we1 = 1'b0;
		nx_a0 = at_q;     nx_d0 = op_q.id;
		nx_a1 = op_q.id;  nx_d1 = after_q;
		pv_a0 = after_q;  pv_d0 = op_q.id;
		pv_a1 = op_q.id;  pv_d1 = at_q;
		unique case (state_q)
			srl_pkg::S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == srl_pkg::OP_REMOVE) state_d = srl_pkg::S_RM_RD;
					else state_d = srl_pkg::S_RD_HEAD;
				end
			end
			srl_pkg::S_RD_HEAD: begin
				key_ra  = head_q;
				state_d = srl_pkg::S_RD_TAIL;
			end
			srl_pkg::S_RD_TAIL: begin
				key_ra  = tail_q;
				state_d = srl_pkg::S_CLASSIFY;
			end
			srl_pkg::S_CLASSIFY: begin
				// key_rd = tail key, hkey_q = head key
				if (listed_q[op_q.id]) state_d = srl_pkg::S_DONE;
				else begin
					key_we = 1'b1;
					if (count_q == '0) state_d = srl_pkg::S_LINK_WR;
					else if (op_q.key <= hkey_q || op_q.key >= key_rd)
						state_d = srl_pkg::S_LINK_RD;
					else state_d = srl_pkg::S_WALK_RD;
				end
			end
			srl_pkg::S_WALK_RD: begin
				link_ra = walk_q;
				state_d = srl_pkg::S_WALK_CMP;
			end
			srl_pkg::S_WALK_CMP: begin
				// next_rd = next of walk; key of it is read now
				key_ra  = next_rd;
				state_d = srl_pkg::S_LINK_RD;
			end
			srl_pkg::S_LINK_RD: begin
				// handled in sequential part; walk loop decision uses key_rd
				link_ra = at_q;
				state_d = srl_pkg::S_LINK_WR;
			end
			srl_pkg::S_LINK_WR: begin
				if (count_q == '0) begin
					nx_we1 = 1'b1; nx_d1 = op_q.id;
					pv_we1 = 1'b1; pv_d1 = op_q.id;
				end else begin
					nx_we0 = 1'b1; nx_we1 = 1'b1; nx_d1 = next_rd;
					pv_we0 = 1'b1; pv_a0 = next_rd; pv_we1 = 1'b1;
				end
				state_d = srl_pkg::S_DONE;
			end
			srl_pkg::S_RM_RD: begin
				link_ra = op_q.id;
				state_d = srl_pkg::S_RM_WR;
			end
			srl_pkg::S_RM_WR: begin
				if (listed_q[op_q.id] && count_q > srl_pkg::cnt_t'(1)) begin
					nx_we0 = 1'b1; nx_a0 = prev_rd; nx_d0 = next_rd;
					pv_we0 = 1'b1; pv_a0 = next_rd; pv_d0 = prev_rd;
				end
				state_d = srl_pkg::S_DONE;
			end
			srl_pkg::S_DONE: begin
				if (!rsp_v_q || rsp_ready) state_d = srl_pkg::S_IDLE;
			end
			default: state_d = srl_pkg::S_IDLE;
		endcase
		// the walk loop: after the key of the successor is back, decide
		if (state_q == srl_pkg::S_LINK_RD && op_q.op == srl_pkg::OP_INSERT
				&& at_q == walk_q && steps_q != '0 && steps_q[srl_pkg::ID_W] == 1'b0
				&& key_rd <= op_q.key) begin
			state_d = srl_pkg::S_WALK_RD;
		end
	end

	// cursor advance needs next_mem[cur]; read it through a small second read
	srl_pkg::id_t cur_next_q;
	always_ff @(posedge clk) begin
		cur_next_q <= next_mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= srl_pkg::S_IDLE;
			listed_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			cur_q    <= '0;
			cur_ok_q <= 1'b0;
			count_q  <= '0;
			rsp_v_q  <= 1'b0;
			steps_q  <= '0;
		end else begin
			state_q <= state_d;
			// loaded when leaving DONE, held until taken
			rsp_v_q <= (state_q == srl_pkg::S_DONE && state_d == srl_pkg::S_IDLE)
				|| (rsp_v_q && !rsp_ready);
			unique case (state_q)
				srl_pkg::S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd;
						walk_q  <= head_q;
						at_q    <= tail_q;
						steps_q <= '0;
					end
				end
				srl_pkg::S_RD_TAIL: hkey_q <= key_rd;
				srl_pkg::S_CLASSIFY: begin
					if (listed_q[op_q.id]) status_q <= srl_pkg::ST_DUP;
					else begin
						status_q <= srl_pkg::ST_OK;
						if (count_q != '0 && op_q.key <= hkey_q) begin
							at_q <= tail_q;
						end else if (count_q != '0 && op_q.key >= key_rd) begin
							at_q <= tail_q;
						end else begin
							at_q <= walk_q;
						end
					end
				end
				srl_pkg::S_WALK_CMP: begin
					steps_q <= steps_q + {{srl_pkg::ID_W{1'b0}}, 1'b1};
					after_q <= next_rd;
				end
				srl_pkg::S_LINK_RD: begin
					if (state_d == srl_pkg::S_WALK_RD) begin
						walk_q <= after_q;
						at_q   <= after_q;
					end
				end
				srl_pkg::S_LINK_WR: begin
					if (count_q == '0) begin
						head_q <= op_q.id;
						tail_q <= op_q.id;
					end else begin
						if (op_q.key <= hkey_q) head_q <= op_q.id;
						else if (at_q == tail_q && steps_q == '0) tail_q <= op_q.id;
					end
					listed_q[op_q.id] <= 1'b1;
					count_q  <= count_q + srl_pkg::cnt_t'(1);
					cur_ok_q <= 1'b1;
					cur_q    <= (count_q != '0 && op_q.key <= hkey_q) ? op_q.id
						: (count_q == '0 ? op_q.id : head_q);
				end
				srl_pkg::S_RM_WR: begin
					if (!listed_q[op_q.id]) status_q <= srl_pkg::ST_ABSENT;
					else begin
						srl_pkg::id_t nc;
						nc = cur_ok_q ? cur_next_q : cur_q;
						status_q <= srl_pkg::ST_OK;
						cur_q <= nc;
						if (nc == op_q.id) cur_ok_q <= 1'b0;
						if (count_q <= srl_pkg::cnt_t'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							if (op_q.id == head_q) head_q <= next_rd;
							if (op_q.id == tail_q) tail_q <= prev_rd;
						end
						listed_q[op_q.id] <= 1'b0;
						count_q <= count_q - srl_pkg::cnt_t'(1);
					end
				end
				srl_pkg::S_DONE: begin
					if (state_d == srl_pkg::S_IDLE) begin
						rsp_q.status       <= status_q;
						rsp_q.head_valid   <= (count_q != '0);
						rsp_q.head_id      <= (count_q != '0) ? head_q : '0;
						rsp_q.cursor_valid <= cur_ok_q;
						rsp_q.cursor_id    <= cur_ok_q ? cur_q : '0;
						rsp_q.entries      <= count_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== design/sorted_ready_list.sv =====
// ----------------------------------------------------------------------------
// sorted_ready_list: key-ordered circular list of node ids
// Inserts and removes nodes of a fixed pool; reports head, cursor and count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): op, node_id, sort_key. One transfer
//   gives exactly one result transfer on the output channel
//   (out_valid/out_ready): status, head_id, head_valid, cursor_id,
//   cursor_valid, entries.
//   A two-entry input queue sits in front of the list engine, so a command
//   may be taken while the engine works or a result waits.
//   An insert reads the head and tail keys, then classifies the key; a
//   middle insert walks from the head with a link read, a key read and a
//   compare per node walked, at most 14 nodes. The engine takes no new
//   command until the previous operation has finished.
//   Reset empties the list and invalidates the cursor; key and link
//   memories are not cleared, since an entry is read only once written.
//   If the receiver stalls, the result is held in the output register and
//   the engine waits before writing the next result.
// ----------------------------------------------------------------------------
module sorted_ready_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [3:0]  node_id,
	input  logic [31:0] sort_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  head_id,
	output logic        head_valid,
	output logic [3:0]  cursor_id,
	output logic        cursor_valid,
	output logic [4:0]  entries
);

	srl_pkg::cmd_t in_cmd, cmd;
	srl_pkg::rsp_t rsp;
	logic          cmd_valid, cmd_ready;

	assign in_cmd.op  = op;
	assign in_cmd.id  = node_id;
	assign in_cmd.key = sort_key;

	srl_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd,
		.cmd_valid, .cmd_ready, .cmd
	);

	srl_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.rsp_valid(out_valid), .rsp_ready(out_ready), .rsp
	);

	assign status       = rsp.status;
	assign head_id      = rsp.head_id;
	assign head_valid   = rsp.head_valid;
	assign cursor_id    = rsp.cursor_id;
	assign cursor_valid = rsp.cursor_valid;
	assign entries      = rsp.entries;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_ready_list
// Drives insert/remove transfers (directed table, then random), predicts each
// result with a behavioral copy of the sorted circular list, compares fields.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIR_N = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = srl_pkg::OP_INSERT;
	logic [3:0]  node_id = '0;
	logic [31:0] sort_key = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [3:0]  head_id;
	logic        head_valid;
	logic [3:0]  cursor_id;
	logic        cursor_valid;
	logic [4:0]  entries;

	sorted_ready_list dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	// list model
	srl_pkg::key_t key_mem [srl_pkg::NODES];
	srl_pkg::id_t  nxt [srl_pkg::NODES];
	srl_pkg::id_t  prv [srl_pkg::NODES];
	bit            listed [srl_pkg::NODES];
	srl_pkg::id_t  head_p, tail_p, cur_p;
	bit            cur_ok;
	int            count;

	srl_pkg::rsp_t result_q[$];
	int   errors = 0;
	bit   tx_done = 1'b0;
	bit   calm = 1'b0;

	function automatic void link_after(srl_pkg::id_t at, srl_pkg::id_t id);
		srl_pkg::id_t aft;
		aft = nxt[at];
		prv[id] = at;
		nxt[id] = aft;
		prv[aft] = id;
		nxt[at] = id;
	endfunction

	function automatic srl_pkg::rsp_t list_step(logic o, srl_pkg::id_t id,
			srl_pkg::key_t k);
		srl_pkg::rsp_t r;
		srl_pkg::id_t w, b, a;
		r = '0;
		r.status = srl_pkg::ST_OK;
		if (o == srl_pkg::OP_INSERT) begin
			if (listed[id]) begin
				r.status = srl_pkg::ST_DUP;
			end else begin
				key_mem[id] = k;
				if (count == 0) begin
					head_p = id; tail_p = id; nxt[id] = id; prv[id] = id;
				end else if (k <= key_mem[head_p]) begin
					link_after(tail_p, id);
					head_p = id;
				end else if (k >= key_mem[tail_p]) begin
					link_after(tail_p, id);
					tail_p = id;
				end else begin
					w = head_p;
					for (int s = 0; s < srl_pkg::NODES; s++) begin
						if (key_mem[nxt[w]] > k) break;
						w = nxt[w];
					end
					link_after(w, id);
				end
				listed[id] = 1'b1;
				count++;
				cur_p = head_p;
				cur_ok = 1'b1;
			end
		end else begin
			if (!listed[id]) begin
				r.status = srl_pkg::ST_ABSENT;
			end else begin
				if (cur_ok) cur_p = nxt[cur_p];
				if (count <= 1) begin
					head_p = '0; tail_p = '0;
				end else begin
					b = prv[id];
					a = nxt[id];
					nxt[b] = a;
					prv[a] = b;
					if (id == head_p) head_p = a;
					if (id == tail_p) tail_p = b;
				end
				listed[id] = 1'b0;
				count--;
				if (cur_p == id) cur_ok = 1'b0;
			end
		end
		r.head_valid = count != 0;
		r.head_id = (count != 0) ? head_p : '0;
		r.cursor_valid = cur_ok;
		r.cursor_id = cur_ok ? cur_p : '0;
		r.entries = srl_pkg::cnt_t'(count);
		return r;
	endfunction

	// holds valid and payload until the transfer; typed result used when given
	task automatic send(logic o, srl_pkg::id_t id, srl_pkg::key_t k, bit use_exp,
			srl_pkg::rsp_t exp_r);
		int gap;
		srl_pkg::rsp_t pred;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		node_id <= id;
		sort_key <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = list_step(o, id, k);
		result_q.push_back(use_exp ? exp_r : pred);
	endtask

	// directed table; expected result typed in where it is obvious
	typedef struct {
		logic          o;
		srl_pkg::id_t  id;
		srl_pkg::key_t k;
		bit            chk;
		srl_pkg::rsp_t exp_r;
	} row_t;

	row_t dir_rows [DIR_N] = '{
		// remove from empty list
		'{srl_pkg::OP_REMOVE, 4'd0,  32'h0, 1'b1,
			'{srl_pkg::ST_ABSENT, 4'd0, 1'b0, 4'd0, 1'b0, 5'd0}},
		// into empty list
		'{srl_pkg::OP_INSERT, 4'd5,  32'h8000_0000, 1'b1,
			'{srl_pkg::ST_OK, 4'd5, 1'b1, 4'd5, 1'b1, 5'd1}},
		// duplicate insert
		'{srl_pkg::OP_INSERT, 4'd5,  32'h1, 1'b1,
			'{srl_pkg::ST_DUP, 4'd5, 1'b1, 4'd5, 1'b1, 5'd1}},
		// min key before head
		'{srl_pkg::OP_INSERT, 4'd0,  32'h0, 1'b1,
			'{srl_pkg::ST_OK, 4'd0, 1'b1, 4'd0, 1'b1, 5'd2}},
		// max key after tail
		'{srl_pkg::OP_INSERT, 4'd15, 32'hFFFF_FFFF, 1'b1,
			'{srl_pkg::ST_OK, 4'd0, 1'b1, 4'd0, 1'b1, 5'd3}},
		'{srl_pkg::OP_INSERT, 4'd7,  32'h8000_0000, 1'b0, '0},  // equal to middle key
		'{srl_pkg::OP_INSERT, 4'd3,  32'h0, 1'b0, '0},          // equal to head key
		'{srl_pkg::OP_INSERT, 4'd9,  32'hFFFF_FFFF, 1'b0, '0},  // equal to tail key
		'{srl_pkg::OP_INSERT, 4'd10, 32'h4000_0000, 1'b0, '0},  // middle walk
		'{srl_pkg::OP_INSERT, 4'd11, 32'hC000_0000, 1'b0, '0},
		'{srl_pkg::OP_REMOVE, 4'd3,  32'hFFFF_FFFF, 1'b0, '0},  // remove head
		'{srl_pkg::OP_REMOVE, 4'd9,  32'h0, 1'b0, '0},          // remove tail
		'{srl_pkg::OP_REMOVE, 4'd2,  32'h0, 1'b0, '0},          // absent
		'{srl_pkg::OP_REMOVE, 4'd10, 32'h0, 1'b0, '0},
		'{srl_pkg::OP_REMOVE, 4'd7,  32'h0, 1'b0, '0},
		'{srl_pkg::OP_REMOVE, 4'd5,  32'h0, 1'b0, '0},
		'{srl_pkg::OP_REMOVE, 4'd11, 32'h0, 1'b0, '0},
		'{srl_pkg::OP_REMOVE, 4'd15, 32'h0, 1'b0, '0},
		'{srl_pkg::OP_REMOVE, 4'd0,  32'h0, 1'b0, '0},          // last node, cursor invalid
		'{srl_pkg::OP_INSERT, 4'd1,  32'h5555_5555, 1'b0, '0}
	};

	initial begin
		srl_pkg::key_t k;
		srl_pkg::id_t  id;
		for (int i = 0; i < srl_pkg::NODES; i++) begin
			listed[i] = 0; key_mem[i] = '0; nxt[i] = '0; prv[i] = '0;
		end
		head_p = '0; tail_p = '0; cur_p = '0; cur_ok = 0; count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send(dir_rows[i].o, dir_rows[i].id, dir_rows[i].k, dir_rows[i].chk,
				dir_rows[i].exp_r);
		for (int n = 0; n < 1800; n++) begin
			if (n > 1600) calm = 1'b1;
			id = srl_pkg::id_t'($urandom_range(0, srl_pkg::NODES - 1));
			// mostly small key range to force ties, sometimes full range
			case ($urandom_range(0, 3))
				0: k = $urandom;
				1: k = $urandom_range(0, 7);
				2: k = {$urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(0, 15);
				default: k = $urandom_range(0, 40);
			endcase
			// bias toward inserts while list is small, removes when full
			if ($urandom_range(0, srl_pkg::NODES) >= count)
				send(srl_pkg::OP_INSERT, id, k, 1'b0, '0);
			else send(srl_pkg::OP_REMOVE, id, $urandom, 1'b0, '0);
		end
		in_valid <= 1'b0;
		tx_done = 1'b1;
	end

	// output side
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				gap = $urandom_range(1, 9);
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		srl_pkg::rsp_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, head_id, head_valid, cursor_id, cursor_valid, entries};
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = result_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (tx_done);
		while (result_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0 && result_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/srl_pkg.sv
design/srl_front.sv
design/srl_back.sv
design/sorted_ready_list.sv
dv/testbench.sv
